/* src/btpt_pkg.sv */
package btpt_pkg;

   // operation codes on the request channel
   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_REFUSED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   // free list commands from the sequencer
   typedef struct packed {
      logic pop;
      logic push;
   } fl_ctrl_type;

endpackage

/* src/btpt_ram.sv */
module btpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/btpt_free_list.sv */
module btpt_free_list #(
   parameter int NODE_COUNT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  btpt_pkg::fl_ctrl_type         ctrl,
   input  logic [$clog2(NODE_COUNT)-1:0] push_idx,
   output logic [$clog2(NODE_COUNT)-1:0] pop_idx,
   output logic [$clog2(NODE_COUNT):0]   count
);

   localparam int IDX_W = $clog2(NODE_COUNT);
   localparam int CNT_W = IDX_W + 1;

   logic [CNT_W-1:0] count_ff, count_in;
   // lowest stack depth ever reached: slots below it still hold their reset value
   logic [CNT_W-1:0] low_ff, low_in;
   logic             init_sel_ff, init_sel_in;
   logic [IDX_W-1:0] init_val_ff, init_val_in;
   logic [IDX_W-1:0] pop_addr;
   logic [IDX_W-1:0] ram_rd;

   assign pop_addr = IDX_W'(count_ff - CNT_W'(1));

   // stack pointer and reset-image tracking
   always_comb begin
      count_in    = count_ff;
      low_in      = low_ff;
      init_sel_in = init_sel_ff;
      init_val_in = init_val_ff;
      if (ctrl.pop) begin
         count_in    = count_ff - CNT_W'(1);
         init_sel_in = CNT_W'(pop_addr) < low_ff;
         init_val_in = IDX_W'(NODE_COUNT - 1) - pop_addr;
         if (CNT_W'(pop_addr) < low_ff) begin
            low_in = CNT_W'(pop_addr);
         end
      end else if (ctrl.push && count_ff < CNT_W'(NODE_COUNT)) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(NODE_COUNT - 1);
         low_ff   <= CNT_W'(NODE_COUNT - 1);
      end else begin
         count_ff <= count_in;
         low_ff   <= low_in;
      end
      init_sel_ff <= init_sel_in;
      init_val_ff <= init_val_in;
   end

   btpt_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NODE_COUNT)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ctrl.push && count_ff < CNT_W'(NODE_COUNT)),
      .wr_addr (IDX_W'(count_ff)),
      .wr_data (push_idx),
      .rd_en   (ctrl.pop),
      .rd_addr (pop_addr),
      .rd_data (ram_rd)
   );

   assign pop_idx = init_sel_ff ? init_val_ff : ram_rd;
   assign count   = count_ff;

endmodule

/* src/binary_trie_prefix_table_core.sv */
// Longest-prefix-match table built as a unibit binary trie in a node memory.
// Request channel (req_*): operation lookup, insert, remove or no-op, with key,
// prefix length, data and replace flag; one transfer starts one operation.
// Response channel (rsp_*): exactly one transfer per request with found,
// data, status and the number of stored prefixes after the operation.
// Operation steps: a walk reads one node memory entry per trie level. Insert
// adds a free list read, then a link write, per new node, plus one write to
// store the data; remove adds one write.
// One operation is in flight at a time; a new request is taken as soon as
// the previous one has reached the response register.
// Reset: synchronous, active high. The root node lives in flip-flops and is
// cleared; the free list starts full with no clearing pass, so requests are
// taken in the first cycle after reset.
// Receiver stall: the finished response waits in the output register; the
// next request is still accepted and walked, and its response holds back
// until the previous one is taken.
module binary_trie_prefix_table_core #(
   parameter int NODE_COUNT = 4096,
   parameter int KEY_BITS   = 32,
   parameter int DATA_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic [KEY_BITS-1:0]             req_key,
   input  logic [$clog2(KEY_BITS+1)-1:0]   req_prefix_len,
   input  logic [DATA_BITS-1:0]            req_data_in,
   input  logic                            req_replace,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output logic [DATA_BITS-1:0]            rsp_data_out,
   output logic [1:0]                      rsp_status,
   output logic [$clog2(NODE_COUNT):0]     rsp_entry_count
);

   localparam int IDX_W = $clog2(NODE_COUNT);
   localparam int CNT_W = IDX_W + 1;
   localparam int DEP_W = $clog2(KEY_BITS + 1);

   typedef struct packed {
      logic                 valid;
      logic [DATA_BITS-1:0] data;
      logic [IDX_W-1:0]     child1;
      logic [IDX_W-1:0]     child0;
   } node_type;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_WALK   = 7'b0000010,
      S_POP    = 7'b0000100,
      S_LINK   = 7'b0001000,
      S_FINAL  = 7'b0010000,
      S_REMOVE = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   btpt_pkg::op_type     op_ff, op_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [DEP_W-1:0]     len_ff, len_in;
   logic [DATA_BITS-1:0] din_ff, din_in;
   logic                 repl_ff, repl_in;
   logic [DEP_W-1:0]     depth_ff, depth_in;
   logic [IDX_W-1:0]     cur_idx_ff, cur_idx_in;
   logic [IDX_W-1:0]     par_idx_ff, par_idx_in;
   logic                 pbit_ff, pbit_in;
   logic                 use_ram_ff, use_ram_in;
   node_type             node_ff, node_in;
   node_type             pnode_ff, pnode_in;
   node_type             root_ff, root_in;
   logic                 found_ff, found_in;
   logic [DATA_BITS-1:0] dout_ff, dout_in;
   btpt_pkg::status_type status_ff, status_in;
   logic [CNT_W-1:0]     entries_ff, entries_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   btpt_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;

   // node write port, shared by root flip-flops and node memory
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;
   node_type             wr_node;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_idx;
   logic [$bits(node_type)-1:0] ram_rd;

   btpt_pkg::fl_ctrl_type fl_ctrl;
   logic [IDX_W-1:0]      fl_push_idx;
   logic [IDX_W-1:0]      fl_pop_idx;
   logic [CNT_W-1:0]      fl_count;

   node_type             cur_node;
   logic [KEY_BITS-1:0]  key_sh;
   logic                 kbit;
   logic [IDX_W-1:0]     child;
   logic [DEP_W-1:0]     limit;
   logic                 stop;
   logic                 hit;
   logic                 freeable;
   logic [DEP_W-1:0]     req_len;

   // current node: root from flip-flops, deeper levels from the memory read
   assign cur_node = use_ram_ff ? node_type'(ram_rd) : root_ff;
   assign key_sh   = key_ff << depth_ff;
   assign kbit     = key_sh[KEY_BITS-1];
   assign child    = kbit ? cur_node.child1 : cur_node.child0;
   assign limit    = (op_ff == btpt_pkg::OP_LOOKUP) ? DEP_W'(KEY_BITS) : len_ff;
   assign stop     = (depth_ff == limit) || (child == '0);
   assign hit      = (depth_ff == len_ff) && cur_node.valid;
   assign freeable = (cur_idx_ff != '0) && (node_ff.child0 == '0) &&
                     (node_ff.child1 == '0);
   assign req_len  = (req_prefix_len > DEP_W'(KEY_BITS)) ? DEP_W'(KEY_BITS)
                                                         : req_prefix_len;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      len_in     = len_ff;
      din_in     = din_ff;
      repl_in    = repl_ff;
      depth_in   = depth_ff;
      cur_idx_in = cur_idx_ff;
      par_idx_in = par_idx_ff;
      pbit_in    = pbit_ff;
      use_ram_in = use_ram_ff;
      node_in    = node_ff;
      pnode_in   = pnode_ff;
      found_in   = found_ff;
      dout_in    = dout_ff;
      status_in  = status_ff;
      entries_in = entries_ff;
      wr_en      = 1'b0;
      wr_idx     = cur_idx_ff;
      wr_node    = node_ff;
      rd_en      = 1'b0;
      rd_idx     = child;
      fl_ctrl    = '0;
      fl_push_idx = cur_idx_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = btpt_pkg::op_type'(req_operation);
               key_in     = req_key;
               len_in     = req_len;
               din_in     = req_data_in;
               repl_in    = req_replace;
               depth_in   = '0;
               cur_idx_in = '0;
               par_idx_in = '0;
               pbit_in    = 1'b0;
               use_ram_in = 1'b0;
               found_in   = 1'b0;
               dout_in    = '0;
               status_in  = btpt_pkg::STATUS_DONE;
               state_in   = (btpt_pkg::op_type'(req_operation) == btpt_pkg::OP_NOP)
                            ? S_OUT : S_WALK;
            end
         end
         S_WALK: begin
            node_in = cur_node;
            if (op_ff == btpt_pkg::OP_LOOKUP && cur_node.valid) begin
               found_in = 1'b1;
               dout_in  = cur_node.data;
            end
            if (!stop) begin
               // descend one level
               pnode_in   = cur_node;
               par_idx_in = cur_idx_ff;
               pbit_in    = kbit;
               cur_idx_in = child;
               depth_in   = depth_ff + DEP_W'(1);
               use_ram_in = 1'b1;
               rd_en      = 1'b1;
            end else begin
               case (op_ff)
                  btpt_pkg::OP_INSERT: begin
                     if (hit) begin
                        found_in = 1'b1;
                        if (repl_ff) begin
                           dout_in      = cur_node.data;
                           wr_en        = 1'b1;
                           wr_node      = cur_node;
                           wr_node.data = din_ff;
                        end else begin
                           dout_in   = din_ff;
                           status_in = btpt_pkg::STATUS_REFUSED;
                        end
                        state_in = S_OUT;
                     end else if (CNT_W'(len_ff - depth_ff) > fl_count) begin
                        dout_in   = din_ff;
                        status_in = btpt_pkg::STATUS_FULL;
                        state_in  = S_OUT;
                     end else if (depth_ff == len_ff) begin
                        state_in = S_FINAL;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  btpt_pkg::OP_REMOVE: begin
                     if (hit) begin
                        found_in = 1'b1;
                        dout_in  = cur_node.data;
                        state_in = S_REMOVE;
                     end else begin
                        state_in = S_OUT;
                     end
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_POP: begin
            fl_ctrl.pop = 1'b1;
            state_in    = S_LINK;
         end
         S_LINK: begin
            // hang the fresh node below the current one and step into it
            wr_en = 1'b1;
            if (kbit) begin
               wr_node.child1 = fl_pop_idx;
            end else begin
               wr_node.child0 = fl_pop_idx;
            end
            node_in    = '0;
            cur_idx_in = fl_pop_idx;
            depth_in   = depth_ff + DEP_W'(1);
            state_in   = (depth_ff + DEP_W'(1) == len_ff) ? S_FINAL : S_POP;
         end
         S_FINAL: begin
            wr_en         = 1'b1;
            wr_node.valid = 1'b1;
            wr_node.data  = din_ff;
            entries_in    = entries_ff + CNT_W'(1);
            state_in      = S_OUT;
         end
         S_REMOVE: begin
            wr_en = 1'b1;
            if (freeable) begin
               // unlink a childless node from its parent and free it
               wr_idx  = par_idx_ff;
               wr_node = pnode_ff;
               if (pbit_ff) begin
                  wr_node.child1 = '0;
               end else begin
                  wr_node.child0 = '0;
               end
               fl_ctrl.push = 1'b1;
            end else begin
               wr_node.valid = 1'b0;
               wr_node.data  = '0;
            end
            if (entries_ff != '0) begin
               entries_in = entries_ff - CNT_W'(1);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_data_in   = dout_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = entries_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // root node update
   always_comb begin
      root_in = root_ff;
      if (wr_en && wr_idx == '0) begin
         root_in = wr_node;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         entries_ff   <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         use_ram_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entries_ff   <= entries_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
         use_ram_ff   <= use_ram_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      len_ff        <= len_in;
      din_ff        <= din_in;
      repl_ff       <= repl_in;
      depth_ff      <= depth_in;
      cur_idx_ff    <= cur_idx_in;
      par_idx_ff    <= par_idx_in;
      pbit_ff       <= pbit_in;
      node_ff       <= node_in;
      pnode_ff      <= pnode_in;
      found_ff      <= found_in;
      dout_ff       <= dout_in;
      status_ff     <= status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // node memory; entry zero is shadowed by the root flip-flops
   btpt_ram #(
      .WIDTH ($bits(node_type)),
      .DEPTH (NODE_COUNT)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en && wr_idx != '0),
      .wr_addr (wr_idx),
      .wr_data (wr_node),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (ram_rd)
   );

   btpt_free_list #(
      .NODE_COUNT (NODE_COUNT)
   ) u_free_list (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (fl_ctrl),
      .push_idx (fl_push_idx),
      .pop_idx  (fl_pop_idx),
      .count    (fl_count)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
